FILE: src/cwmmd_pkg.sv
// Package for the change watch min/max decimator.
// Holds the widths, payload types, register and code enums and the job format
// shared by the interfaces and modules. Depends on nothing.
package cwmmd_pkg;

  localparam int unsigned LANES       = 4;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned TIME_WIDTH  = 48;

  localparam int unsigned STEP_WIDTH     = 16;
  localparam int unsigned INTERVAL_WIDTH = 24;
  localparam int unsigned LANES_WIDTH    = 3;
  localparam int unsigned OMIT_WIDTH     = 16;
  localparam int unsigned CFG_DATA_WIDTH = 24;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  localparam int unsigned STEP_RESET     = 1;
  localparam int unsigned INTERVAL_RESET = 1000;
  localparam int unsigned LANES_RESET    = 4;

  // floor(x / 3) = (x * THIRD_RECIP) >> THIRD_SHIFT for x below 2**25.
  localparam int unsigned THIRD_SHIFT = 26;
  localparam logic [THIRD_SHIFT-1:0] THIRD_RECIP =
      THIRD_SHIFT'((64'd1 << THIRD_SHIFT) / 3 + 1);
  localparam int unsigned THIRD_RESET     = INTERVAL_RESET / 3;
  localparam int unsigned TWO_THIRD_RESET = (2 * INTERVAL_RESET) / 3;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef value_t [LANES-1:0] lane_vals_t;
  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [INTERVAL_WIDTH-1:0] interval_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MODE     = 2'd0,
    REG_STEP     = 2'd1,
    REG_INTERVAL = 2'd2,
    REG_LANES    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    MODE_FIXED = 1'b0,
    MODE_AUTO  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_MAX    = 2'd1,
    KIND_MIN    = 2'd2,
    KIND_CLOSE  = 2'd3
  } out_kind_e;

  typedef enum logic [1:0] {
    JOB_SAMPLE = 2'd0,
    JOB_SINGLE = 2'd1,
    JOB_TRIPLE = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  sample_time;
    logic signed [VALUE_WIDTH-1:0] value_a;
    logic signed [VALUE_WIDTH-1:0] value_b;
    logic signed [VALUE_WIDTH-1:0] value_c;
    logic signed [VALUE_WIDTH-1:0] value_d;
  } sample_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  out_time;
    logic [1:0]             out_kind;
    logic signed [VALUE_WIDTH-1:0] out_a;
    logic signed [VALUE_WIDTH-1:0] out_b;
    logic signed [VALUE_WIDTH-1:0] out_c;
    logic signed [VALUE_WIDTH-1:0] out_d;
    logic                   out_last;
  } point_t;

  // One queued emission: the base time and every value set it may need.
  typedef struct packed {
    job_kind_e  kind;
    time_t      base_time;
    lane_vals_t cur;
    lane_vals_t lo;
    lane_vals_t hi;
  } job_t;

  // Time offsets of the pent-up points, derived from the interval register.
  typedef struct packed {
    interval_t third;
    interval_t two_third;
    interval_t full;
  } offsets_t;

endpackage

FILE: src/cwmmd_if.sv
// Handshake channel interfaces for samples, result points and register writes.
// Depends on cwmmd_pkg for the payload types.
interface cwmmd_sample_if;
  import cwmmd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cwmmd_point_if;
  import cwmmd_pkg::*;

  logic   valid;
  logic   ready;
  point_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cwmmd_cfg_if;
  import cwmmd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/cwmmd_front.sv
// Front end: configuration registers, per-sample classification and all
// decimator state. Pushes one job per emitting sample. Depends on cwmmd_pkg.
module cwmmd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  cwmmd_sample_if.sink        in_i,
  cwmmd_cfg_if.sink           cfg_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output cwmmd_pkg::job_t     q_job_o,
  output cwmmd_pkg::offsets_t offs_o
);
  import cwmmd_pkg::*;

  logic                        mode_q;
  logic [STEP_WIDTH-1:0]       step_q;
  interval_t                   ival_q, third_q, two_third_q;
  logic [LANES_WIDTH-1:0]      lanes_q;

  lane_vals_t                  held_q, lo_q, hi_q;
  lane_vals_t                  held_d, lo_d, hi_d;
  logic                        held_valid_q, held_valid_d;
  logic [OMIT_WIDTH-1:0]       omit_q, omit_d;
  time_t                       let_q, let_d;
  logic                        lev_q, lev_d;
  logic [STEP_WIDTH-1:0]       stride_q, stride_d;

  logic [LANES_WIDTH-1:0]      n_eff;
  logic [LANES-1:0]            act;
  lane_vals_t                  v_in, v;
  lane_vals_t                  lo_act, hi_act;
  logic [STEP_WIDTH-1:0]       step_eff;
  logic [STEP_WIDTH:0]         stride_inc;
  logic                        accept, check, changed, same, in_window;
  time_t                       t, t_diff;
  logic                        emit;
  job_t                        job;

  logic [INTERVAL_WIDTH+THIRD_SHIFT-1:0]   third_prod;
  logic [INTERVAL_WIDTH+THIRD_SHIFT:0]     two_third_prod;

  // Configuration port, always ready; thirds of the interval are worked out
  // on the write so the output side only adds.
  assign cfg_i.ready = 1'b1;
  assign third_prod = cfg_i.data[INTERVAL_WIDTH-1:0] * THIRD_RECIP;
  assign two_third_prod = {cfg_i.data[INTERVAL_WIDTH-1:0], 1'b0} * THIRD_RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FIXED;
      step_q      <= STEP_WIDTH'(STEP_RESET);
      ival_q      <= INTERVAL_WIDTH'(INTERVAL_RESET);
      third_q     <= INTERVAL_WIDTH'(THIRD_RESET);
      two_third_q <= INTERVAL_WIDTH'(TWO_THIRD_RESET);
      lanes_q     <= LANES_WIDTH'(LANES_RESET);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_MODE: mode_q <= cfg_i.data[0];
        REG_STEP: step_q <= cfg_i.data[STEP_WIDTH-1:0];
        REG_INTERVAL: begin
          ival_q      <= cfg_i.data[INTERVAL_WIDTH-1:0];
          third_q     <= third_prod[THIRD_SHIFT +: INTERVAL_WIDTH];
          two_third_q <= two_third_prod[THIRD_SHIFT +: INTERVAL_WIDTH];
        end
        REG_LANES: lanes_q <= cfg_i.data[LANES_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign offs_o = '{third: third_q, two_third: two_third_q, full: ival_q};

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  assign t = in_i.data.sample_time;
  assign v_in[0] = in_i.data.value_a;
  assign v_in[1] = in_i.data.value_b;
  assign v_in[2] = in_i.data.value_c;
  assign v_in[3] = in_i.data.value_d;

  always_comb begin
    if (lanes_q == '0) begin
      n_eff = LANES_WIDTH'(1);
    end else if (lanes_q > LANES_WIDTH'(LANES)) begin
      n_eff = LANES_WIDTH'(LANES);
    end else begin
      n_eff = lanes_q;
    end
    for (int i = 0; i < LANES; i++) begin
      act[i]    = LANES_WIDTH'(i) < n_eff;
      v[i]      = act[i] ? v_in[i] : '0;
      lo_act[i] = act[i] ? lo_q[i] : '0;
      hi_act[i] = act[i] ? hi_q[i] : '0;
    end
  end

  assign step_eff   = (step_q == '0) ? STEP_WIDTH'(1) : step_q;
  assign stride_inc = {1'b0, stride_q} + (STEP_WIDTH+1)'(1);
  assign check      = (stride_q == '0);
  assign t_diff     = t - let_q;
  assign in_window  = lev_q && (t > let_q) &&
                      (t_diff <= TIME_WIDTH'(ival_q));

  always_comb begin
    changed = !held_valid_q;
    same    = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      if (v[i] != held_q[i]) changed = 1'b1;
      if (act[i] && (lo_q[i] != hi_q[i])) same = 1'b0;
    end
  end

  always_comb begin
    held_d       = held_q;
    held_valid_d = held_valid_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    omit_d       = omit_q;
    let_d        = let_q;
    lev_d        = lev_q;
    stride_d     = stride_q;
    emit         = 1'b0;
    job          = '{kind: JOB_SAMPLE, base_time: t, cur: v, lo: lo_act, hi: hi_act};

    if (accept) begin
      if (mode_q == MODE_FIXED) begin
        stride_d = (stride_inc >= {1'b0, step_eff}) ? '0 : stride_inc[STEP_WIDTH-1:0];
        if (check) begin
          held_d       = v;
          held_valid_d = 1'b1;
          if (changed) begin
            emit   = 1'b1;
            let_d  = t;
            lev_d  = 1'b1;
            omit_d = '0;
          end
        end
      end else begin
        held_d       = v;
        held_valid_d = 1'b1;
        if (in_window) begin
          for (int i = 0; i < LANES; i++) begin
            if (act[i] && (v[i] < lo_q[i])) lo_d[i] = v[i];
            if (act[i] && (v[i] > hi_q[i])) hi_d[i] = v[i];
          end
          if (omit_q != '1) omit_d = omit_q + OMIT_WIDTH'(1);
        end else begin
          emit = 1'b1;
          if (omit_q != '0) begin
            job.base_time = let_q;
            job.kind      = same ? JOB_SINGLE : JOB_TRIPLE;
          end
          lo_d   = v;
          hi_d   = v;
          let_d  = t;
          lev_d  = 1'b1;
          omit_d = '0;
        end
      end
    end
  end

  assign q_push_o = emit;
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      held_valid_q <= 1'b0;
      lo_q         <= '0;
      hi_q         <= '0;
      omit_q       <= '0;
      let_q        <= '0;
      lev_q        <= 1'b0;
      stride_q     <= '0;
    end else begin
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      omit_q       <= omit_d;
      let_q        <= let_d;
      lev_q        <= lev_d;
      stride_q     <= stride_d;
    end
  end

endmodule

FILE: src/cwmmd_queue.sv
// Short job queue between the front and back ends.
// Depends on cwmmd_pkg for the job type and the queue depth.
module cwmmd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cwmmd_pkg::job_t job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cwmmd_pkg::job_t job_o
);
  import cwmmd_pkg::*;

  job_t                  slot_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_q, rd_q;
  logic [QCNT_WIDTH-1:0] cnt_q;
  logic                  do_pop;

  assign full_o  = (cnt_q == QCNT_WIDTH'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= QPTR_WIDTH'((32'(wr_q) + 1) % QUEUE_DEPTH);
      if (do_pop) rd_q <= QPTR_WIDTH'((32'(rd_q) + 1) % QUEUE_DEPTH);
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCNT_WIDTH'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - QCNT_WIDTH'(1);
      end
    end
  end

endmodule

FILE: src/cwmmd_back.sv
// Back end: expands queued jobs into one or three result beats and holds
// them in the output register. Depends on cwmmd_pkg.
module cwmmd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  cwmmd_pkg::job_t     job_i,
  input  cwmmd_pkg::offsets_t offs_i,
  output logic                pop_o,
  cwmmd_point_if.source       out_o
);
  import cwmmd_pkg::*;

  logic [1:0]  beat_q, beat_d;
  logic        out_valid_q;
  point_t      out_q, pt;
  logic        load, last_beat;
  lane_vals_t  vals;
  interval_t   offs;

  assign load      = job_valid_i && (!out_valid_q || out_o.ready);
  assign last_beat = (job_i.kind != JOB_TRIPLE) || (beat_q == 2'd2);
  assign pop_o     = load && last_beat;
  assign beat_d    = load ? (last_beat ? 2'd0 : beat_q + 2'd1) : beat_q;

  always_comb begin
    pt.out_last = last_beat;
    case (job_i.kind)
      JOB_SAMPLE: begin
        offs        = '0;
        pt.out_kind = KIND_SAMPLE;
        vals        = job_i.cur;
      end
      JOB_SINGLE: begin
        offs        = offs_i.full;
        pt.out_kind = KIND_MIN;
        vals        = job_i.lo;
      end
      default: begin
        // A burst runs maximum, minimum, then the closing values.
        case (beat_q)
          2'd0: begin
            offs        = offs_i.third;
            pt.out_kind = KIND_MAX;
            vals        = job_i.hi;
          end
          2'd1: begin
            offs        = offs_i.two_third;
            pt.out_kind = KIND_MIN;
            vals        = job_i.lo;
          end
          default: begin
            offs        = offs_i.full;
            pt.out_kind = KIND_CLOSE;
            vals        = job_i.cur;
          end
        endcase
      end
    endcase
    pt.out_time = job_i.base_time + TIME_WIDTH'(offs);
    pt.out_a    = vals[0];
    pt.out_b    = vals[1];
    pt.out_c    = vals[2];
    pt.out_d    = vals[3];
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= pt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      beat_q <= beat_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

FILE: src/change_watch_min_max_decimator.sv
// Top level of the change watch min/max decimator.
// Depends on cwmmd_pkg, the channel interfaces, cwmmd_front, cwmmd_queue, cwmmd_back.
//
// The block takes one sample per clock and updates all of its state in the
// cycle a sample is accepted; a sample that emits leaves a job in a four-entry
// queue. The output side turns each job into one result beat per cycle while
// the output is ready, through a registered output stage; a plain emission
// gives one beat and a pent-up min/max burst three. Input stalls only while
// that queue is full, as when bursts or a stalled output back up four jobs.
// Register writes take effect on the next clock; the interval's thirds are
// computed on the write. There is no clearing pass after reset.
module change_watch_min_max_decimator (
  input logic           clk_i,
  input logic           rst_ni,
  cwmmd_sample_if.sink  in_i,
  cwmmd_cfg_if.sink     cfg_i,
  cwmmd_point_if.source out_o
);
  import cwmmd_pkg::*;

  logic     q_push, q_full, q_pop, q_valid;
  job_t     q_wjob, q_rjob;
  offsets_t offs;

  cwmmd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (q_wjob),
    .offs_o   (offs)
  );

  cwmmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_wjob),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_rjob)
  );

  cwmmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_rjob),
    .offs_i      (offs),
    .pop_o       (q_pop),
    .out_o       (out_o)
  );

endmodule
